// File: sv/qers_pkg.sv
`default_nettype none
package qers_pkg;

  localparam int COEF_WIDTH_DEF = 16;

  // result field widths
  localparam int KIND_W = 3;
  localparam int NUM_W  = 18;
  localparam int DEN_W  = 17;
  localparam int RAT_W  = 17;
  localparam int RADC_W = 17;
  localparam int REST_W = 33;

  localparam logic [KIND_W-1:0] KIND_NONE     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DOUBLE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RATIONAL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_IRRATION = 3'd3;
  localparam logic [KIND_W-1:0] KIND_A_ZERO   = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE, S_BB, S_AC, S_DELTA, S_CLASS,
    S_PSQ, S_PCMP, S_PDIV, S_PDIV2, S_KMUL, S_KSTORE,
    S_KSQ, S_KSQ2, S_RDIV,
    S_RED, S_GLOAD, S_GCD, S_GWAIT, S_SWAIT, S_RDONE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

// File: sv/qers_if.sv
`default_nettype none
interface qers_in_if #(parameter int COEF_WIDTH = qers_pkg::COEF_WIDTH_DEF);
  logic valid;
  logic ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qers_out_if;
  logic valid;
  logic ready;
  logic        [qers_pkg::KIND_W-1:0] kind;
  logic signed [qers_pkg::NUM_W-1:0]  first_num;
  logic signed [qers_pkg::DEN_W-1:0]  first_den;
  logic signed [qers_pkg::NUM_W-1:0]  second_num;
  logic signed [qers_pkg::DEN_W-1:0]  second_den;
  logic signed [qers_pkg::RAT_W-1:0]  rational_part;
  logic        [qers_pkg::RADC_W-1:0] radical_coeff;
  logic        [qers_pkg::REST_W-1:0] radical_rest;
  logic signed [qers_pkg::DEN_W-1:0]  irr_den;

  modport source (output valid, kind, first_num, first_den, second_num, second_den,
                  rational_part, radical_coeff, radical_rest, irr_den, input ready);
  modport sink   (input valid, kind, first_num, first_den, second_num, second_den,
                  rational_part, radical_coeff, radical_rest, irr_den, output ready);
endinterface
`default_nettype wire

// File: sv/quadratic_exact_root_solver_core.sv
// Exact-root quadratic solver: a*x*x + b*x + c = 0, integer coefficients.
// in_ch (valid/ready) carries coef_a, coef_b, coef_c; out_ch carries one result
// item per input item: kind plus the reduced fractions or the radical form
// -b' +- k'*sqrt(r) over d'. Fields not used by the reported kind are 0.
// in_ch.ready is high only while the sequencer is idle; one item is worked at
// a time. All products and quotients run through one multiplier and one
// bit-serial divider. a = 0 and a negative or zero discriminant skip the
// trial division. Otherwise trial division over p = 2 .. sqrt(remaining
// discriminant) dominates, then a short gcd pass reduces the result.
// The result sits in an output register; the next item is accepted while it
// waits, and a finished result waits in the sequencer if out_ch stalls.
// Reset (rst_n, synchronous, active low) returns to idle and drops out valid.
`default_nettype none
module quadratic_exact_root_solver_core #(
  parameter int COEF_WIDTH = qers_pkg::COEF_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  qers_in_if.sink  in_ch,
  qers_out_if.source out_ch
);

  localparam int W   = COEF_WIDTH;
  localparam int VW  = 2 * W + 2;   // signed working values, discriminant
  localparam int DW  = 2 * W + 1;   // unsigned divider width
  localparam int PW  = W + 2;       // trial divisor, square factor k
  localparam int MW  = W + 3;       // multiplier operand
  localparam int PRW = 2 * MW;      // product

  qers_pkg::state_t state_r, state_nxt;

  logic signed [W-1:0]   a_r, b_r, c_r;
  logic signed [VW-1:0]  delta_r, delta_nxt;
  logic [DW-1:0]         m_r, m_nxt;
  logic [PW-1:0]         p_r, p_nxt, k_r, k_nxt;
  logic signed [PRW-1:0] prod_r;
  logic signed [MW-1:0]  mul_x, mul_y;

  // reduction operands, rotated so the head is always the one worked on
  logic signed [VW-1:0]  v_r [3];
  logic signed [VW-1:0]  v_nxt [3];
  logic                  rn3_r, rn3_nxt;
  logic [1:0]            ri_r, ri_nxt, rn;
  logic [DW-1:0]         g_r, g_nxt, gy_r, gy_nxt;
  logic [qers_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic                  ph_r, ph_nxt;

  // staged result
  logic signed [qers_pkg::NUM_W-1:0]  fnum_r, fnum_nxt, snum_r, snum_nxt;
  logic signed [qers_pkg::DEN_W-1:0]  fden_r, fden_nxt, sden_r, sden_nxt;
  logic signed [qers_pkg::DEN_W-1:0]  iden_r, iden_nxt;
  logic signed [qers_pkg::RAT_W-1:0]  rat_r, rat_nxt;
  logic [qers_pkg::RADC_W-1:0]        coef_r, coef_nxt;
  logic [qers_pkg::REST_W-1:0]        rrest_r, rrest_nxt;

  // output register
  logic                               out_valid_r;
  logic [qers_pkg::KIND_W-1:0]        out_kind_r;
  logic signed [qers_pkg::NUM_W-1:0]  out_fnum_r, out_snum_r;
  logic signed [qers_pkg::DEN_W-1:0]  out_fden_r, out_sden_r, out_iden_r;
  logic signed [qers_pkg::RAT_W-1:0]  out_rat_r;
  logic [qers_pkg::RADC_W-1:0]        out_coef_r;
  logic [qers_pkg::REST_W-1:0]        out_rest_r;
  logic                               load_out;

  qers_pkg::div_ctl_t div_ctl;
  qers_pkg::div_sts_t div_sts;
  logic [DW-1:0]      div_n, div_d, div_quo, div_rem;

  logic signed [VW-1:0] neg_b, den2a, kval, new_head;
  logic                 accept;

  function automatic logic [DW-1:0] mag(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] t;
    t = v[VW-1] ? -v : v;
    return t[DW-1:0];
  endfunction

  qers_div #(.DW(DW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (div_ctl),
    .dividend(div_n),
    .divisor (div_d),
    .sts     (div_sts),
    .quo     (div_quo),
    .rem     (div_rem)
  );

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == qers_pkg::S_IDLE);
  assign neg_b       = -VW'(b_r);
  assign den2a       = VW'(a_r) <<< 1;
  assign kval        = VW'(k_r);
  assign rn          = rn3_r ? 2'd3 : 2'd2;
  assign new_head    = v_r[0][VW-1] ? -VW'(div_quo) : VW'(div_quo);
  assign load_out    = (state_r == qers_pkg::S_OUT) && (!out_valid_r || out_ch.ready);

  // shared multiplier, registered
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state_r)
      qers_pkg::S_BB:   begin mul_x = MW'(b_r); mul_y = MW'(b_r); end
      qers_pkg::S_AC:   begin mul_x = MW'(a_r); mul_y = MW'(c_r); end
      qers_pkg::S_PSQ:  begin mul_x = $signed(MW'(p_r)); mul_y = $signed(MW'(p_r)); end
      qers_pkg::S_KMUL: begin mul_x = $signed(MW'(k_r)); mul_y = $signed(MW'(p_r)); end
      qers_pkg::S_KSQ:  begin mul_x = $signed(MW'(k_r)); mul_y = $signed(MW'(k_r)); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_x * mul_y;
  end

  always_comb begin
    state_nxt = state_r;
    delta_nxt = delta_r;
    m_nxt     = m_r;
    p_nxt     = p_r;
    k_nxt     = k_r;
    v_nxt     = v_r;
    rn3_nxt   = rn3_r;
    ri_nxt    = ri_r;
    g_nxt     = g_r;
    gy_nxt    = gy_r;
    kind_nxt  = kind_r;
    ph_nxt    = ph_r;
    fnum_nxt  = fnum_r;
    fden_nxt  = fden_r;
    snum_nxt  = snum_r;
    sden_nxt  = sden_r;
    iden_nxt  = iden_r;
    rat_nxt   = rat_r;
    coef_nxt  = coef_r;
    rrest_nxt = rrest_r;
    div_ctl.start = 1'b0;
    div_n     = '0;
    div_d     = '0;

    case (state_r)
      qers_pkg::S_IDLE: begin
        if (accept) begin
          fnum_nxt  = '0;
          fden_nxt  = '0;
          snum_nxt  = '0;
          sden_nxt  = '0;
          iden_nxt  = '0;
          rat_nxt   = '0;
          coef_nxt  = '0;
          rrest_nxt = '0;
          if (in_ch.coef_a == '0) begin
            kind_nxt  = qers_pkg::KIND_A_ZERO;
            state_nxt = qers_pkg::S_OUT;
          end else begin
            state_nxt = qers_pkg::S_BB;
          end
        end
      end
      qers_pkg::S_BB: state_nxt = qers_pkg::S_AC;
      qers_pkg::S_AC: begin
        delta_nxt = VW'(prod_r);
        state_nxt = qers_pkg::S_DELTA;
      end
      qers_pkg::S_DELTA: begin
        delta_nxt = delta_r - (VW'(prod_r) <<< 2);
        state_nxt = qers_pkg::S_CLASS;
      end
      qers_pkg::S_CLASS: begin
        if (delta_r[VW-1]) begin
          kind_nxt  = qers_pkg::KIND_NONE;
          state_nxt = qers_pkg::S_OUT;
        end else if (delta_r == '0) begin
          kind_nxt  = qers_pkg::KIND_DOUBLE;
          v_nxt[0]  = neg_b;
          v_nxt[1]  = den2a;
          rn3_nxt   = 1'b0;
          state_nxt = qers_pkg::S_RED;
        end else begin
          m_nxt     = delta_r[DW-1:0];
          k_nxt     = PW'(1);
          p_nxt     = PW'(2);
          state_nxt = qers_pkg::S_PSQ;
        end
      end
      // trial division for the square factor k
      qers_pkg::S_PSQ: state_nxt = qers_pkg::S_PCMP;
      qers_pkg::S_PCMP: begin
        if ($unsigned(prod_r) > PRW'(m_r)) begin
          state_nxt = qers_pkg::S_KSQ;
        end else begin
          div_ctl.start = 1'b1;
          div_n     = m_r;
          div_d     = DW'(p_r);
          state_nxt = qers_pkg::S_PDIV;
        end
      end
      qers_pkg::S_PDIV: begin
        if (div_sts.done) begin
          if (div_rem == '0) begin
            m_nxt     = div_quo;
            div_ctl.start = 1'b1;
            div_n     = div_quo;
            div_d     = DW'(p_r);
            state_nxt = qers_pkg::S_PDIV2;
          end else begin
            p_nxt     = p_r + PW'(1);
            state_nxt = qers_pkg::S_PSQ;
          end
        end
      end
      qers_pkg::S_PDIV2: begin
        if (div_sts.done) begin
          if (div_rem == '0) begin
            m_nxt     = div_quo;
            state_nxt = qers_pkg::S_KMUL;
          end else begin
            // odd exponent: one factor p stays
            p_nxt     = p_r + PW'(1);
            state_nxt = qers_pkg::S_PSQ;
          end
        end
      end
      qers_pkg::S_KMUL: state_nxt = qers_pkg::S_KSTORE;
      qers_pkg::S_KSTORE: begin
        k_nxt     = prod_r[PW-1:0];
        div_ctl.start = 1'b1;
        div_n     = m_r;
        div_d     = DW'(p_r);
        state_nxt = qers_pkg::S_PDIV;
      end
      // r = delta / (k*k); r == 1 means a perfect square with s = k
      qers_pkg::S_KSQ: state_nxt = qers_pkg::S_KSQ2;
      qers_pkg::S_KSQ2: begin
        div_ctl.start = 1'b1;
        div_n     = delta_r[DW-1:0];
        div_d     = prod_r[DW-1:0];
        state_nxt = qers_pkg::S_RDIV;
      end
      qers_pkg::S_RDIV: begin
        if (div_sts.done) begin
          if (div_quo == DW'(1)) begin
            kind_nxt  = qers_pkg::KIND_RATIONAL;
            ph_nxt    = 1'b0;
            v_nxt[0]  = neg_b + kval;
            v_nxt[1]  = den2a;
            rn3_nxt   = 1'b0;
            state_nxt = qers_pkg::S_RED;
          end else begin
            kind_nxt  = qers_pkg::KIND_IRRATION;
            rrest_nxt = qers_pkg::REST_W'(div_quo);
            if (k_r == PW'(1)) begin
              rat_nxt   = qers_pkg::RAT_W'(neg_b);
              coef_nxt  = qers_pkg::RADC_W'(1);
              iden_nxt  = qers_pkg::DEN_W'(den2a);
              state_nxt = qers_pkg::S_OUT;
            end else if (b_r == '0) begin
              v_nxt[0]  = kval;
              v_nxt[1]  = den2a;
              rn3_nxt   = 1'b0;
              state_nxt = qers_pkg::S_RED;
            end else begin
              v_nxt[0]  = VW'(b_r);
              v_nxt[1]  = kval;
              v_nxt[2]  = den2a;
              rn3_nxt   = 1'b1;
              state_nxt = qers_pkg::S_RED;
            end
          end
        end
      end
      // common-factor reduction over two or three values
      qers_pkg::S_RED: begin
        if (v_r[0] == '0 || v_r[1] == '0 || (rn3_r && v_r[2] == '0)) begin
          state_nxt = qers_pkg::S_RDONE;
        end else begin
          g_nxt     = mag(v_r[0]);
          v_nxt[0]  = v_r[1];
          v_nxt[1]  = rn3_r ? v_r[2] : v_r[0];
          v_nxt[2]  = rn3_r ? v_r[0] : v_r[2];
          ri_nxt    = 2'd1;
          state_nxt = qers_pkg::S_GLOAD;
        end
      end
      qers_pkg::S_GLOAD: begin
        gy_nxt    = mag(v_r[0]);
        v_nxt[0]  = v_r[1];
        v_nxt[1]  = rn3_r ? v_r[2] : v_r[0];
        v_nxt[2]  = rn3_r ? v_r[0] : v_r[2];
        ri_nxt    = ri_r + 2'd1;
        state_nxt = qers_pkg::S_GCD;
      end
      qers_pkg::S_GCD: begin
        if (gy_r == '0) begin
          if (ri_r == rn) begin
            if (g_r > DW'(1)) begin
              ri_nxt    = 2'd0;
              div_ctl.start = 1'b1;
              div_n     = mag(v_r[0]);
              div_d     = g_r;
              state_nxt = qers_pkg::S_SWAIT;
            end else begin
              state_nxt = qers_pkg::S_RDONE;
            end
          end else begin
            state_nxt = qers_pkg::S_GLOAD;
          end
        end else begin
          div_ctl.start = 1'b1;
          div_n     = g_r;
          div_d     = gy_r;
          state_nxt = qers_pkg::S_GWAIT;
        end
      end
      qers_pkg::S_GWAIT: begin
        if (div_sts.done) begin
          g_nxt     = gy_r;
          gy_nxt    = div_rem;
          state_nxt = qers_pkg::S_GCD;
        end
      end
      qers_pkg::S_SWAIT: begin
        if (div_sts.done) begin
          v_nxt[0] = v_r[1];
          v_nxt[1] = rn3_r ? v_r[2] : new_head;
          v_nxt[2] = rn3_r ? new_head : v_r[2];
          ri_nxt   = ri_r + 2'd1;
          if (2'(ri_r + 2'd1) == rn) begin
            state_nxt = qers_pkg::S_RDONE;
          end else begin
            div_ctl.start = 1'b1;
            div_n     = mag(v_r[1]);
            div_d     = g_r;
          end
        end
      end
      qers_pkg::S_RDONE: begin
        state_nxt = qers_pkg::S_OUT;
        case (kind_r)
          qers_pkg::KIND_DOUBLE: begin
            fnum_nxt = qers_pkg::NUM_W'(v_r[0]);
            fden_nxt = qers_pkg::DEN_W'(v_r[1]);
          end
          qers_pkg::KIND_RATIONAL: begin
            if (!ph_r) begin
              fnum_nxt  = qers_pkg::NUM_W'(v_r[0]);
              fden_nxt  = qers_pkg::DEN_W'(v_r[1]);
              ph_nxt    = 1'b1;
              v_nxt[0]  = neg_b - kval;
              v_nxt[1]  = den2a;
              state_nxt = qers_pkg::S_RED;
            end else begin
              snum_nxt = qers_pkg::NUM_W'(v_r[0]);
              sden_nxt = qers_pkg::DEN_W'(v_r[1]);
            end
          end
          default: begin
            if (rn3_r) begin
              rat_nxt  = qers_pkg::RAT_W'(-v_r[0]);
              coef_nxt = qers_pkg::RADC_W'(v_r[1]);
              iden_nxt = qers_pkg::DEN_W'(v_r[2]);
            end else begin
              rat_nxt  = '0;
              coef_nxt = qers_pkg::RADC_W'(v_r[0]);
              iden_nxt = qers_pkg::DEN_W'(v_r[1]);
            end
          end
        endcase
      end
      qers_pkg::S_OUT: begin
        if (load_out) state_nxt = qers_pkg::S_IDLE;
      end
      default: state_nxt = qers_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qers_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_r <= in_ch.coef_a;
      b_r <= in_ch.coef_b;
      c_r <= in_ch.coef_c;
    end
    delta_r <= delta_nxt;
    m_r     <= m_nxt;
    p_r     <= p_nxt;
    k_r     <= k_nxt;
    v_r     <= v_nxt;
    rn3_r   <= rn3_nxt;
    ri_r    <= ri_nxt;
    g_r     <= g_nxt;
    gy_r    <= gy_nxt;
    kind_r  <= kind_nxt;
    ph_r    <= ph_nxt;
    fnum_r  <= fnum_nxt;
    fden_r  <= fden_nxt;
    snum_r  <= snum_nxt;
    sden_r  <= sden_nxt;
    iden_r  <= iden_nxt;
    rat_r   <= rat_nxt;
    coef_r  <= coef_nxt;
    rrest_r <= rrest_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind_r <= kind_r;
      out_fnum_r <= fnum_r;
      out_fden_r <= fden_r;
      out_snum_r <= snum_r;
      out_sden_r <= sden_r;
      out_rat_r  <= rat_r;
      out_coef_r <= coef_r;
      out_rest_r <= rrest_r;
      out_iden_r <= iden_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_kind_r;
  assign out_ch.first_num     = out_fnum_r;
  assign out_ch.first_den     = out_fden_r;
  assign out_ch.second_num    = out_snum_r;
  assign out_ch.second_den    = out_sden_r;
  assign out_ch.rational_part = out_rat_r;
  assign out_ch.radical_coeff = out_coef_r;
  assign out_ch.radical_rest  = out_rest_r;
  assign out_ch.irr_den       = out_iden_r;

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_sts.busy) else $error("divider started while busy");
  a_rest_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qers_pkg::S_RDIV && div_sts.done) |-> div_quo != '0)
    else $error("square-free part is zero");
  a_exact_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qers_pkg::S_SWAIT && div_sts.done) |-> div_rem == '0)
    else $error("common factor does not divide");
  a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && kind_r == qers_pkg::KIND_NONE) |-> (fnum_r == '0 && coef_r == '0))
    else $error("no-root result carries data");

endmodule
`default_nettype wire

// File: sv/qers_div.sv
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle.
module qers_div #(
  parameter int DW = 33
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire qers_pkg::div_ctl_t ctl,
  input  wire logic [DW-1:0]      dividend,
  input  wire logic [DW-1:0]      divisor,
  output qers_pkg::div_sts_t      sts,
  output logic [DW-1:0]           quo,
  output logic [DW-1:0]           rem
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r, rem_r, den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial, diff;
  logic          ge;

  assign trial = {rem_r, quo_r[DW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        den_r  <= divisor;
        cnt_r  <= CW'(DW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_r <= {quo_r[DW-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;
  assign rem      = rem_r;

  a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> busy_r) else $error("divider did not start");
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");

endmodule
`default_nettype wire

// File: tb/tb_top.sv
module tb_top;

  // Expected result item, laid out at the result channel's field widths.
  typedef struct {
    logic        [qers_pkg::KIND_W-1:0] kind;
    logic signed [qers_pkg::NUM_W-1:0]  first_num;
    logic signed [qers_pkg::DEN_W-1:0]  first_den;
    logic signed [qers_pkg::NUM_W-1:0]  second_num;
    logic signed [qers_pkg::DEN_W-1:0]  second_den;
    logic signed [qers_pkg::RAT_W-1:0]  rational_part;
    logic        [qers_pkg::RADC_W-1:0] radical_coeff;
    logic        [qers_pkg::REST_W-1:0] radical_rest;
    logic signed [qers_pkg::DEN_W-1:0]  irr_den;
  } roots_t;

  logic clk;
  logic rst_n;
  int   fails;
  roots_t pending_roots[$];

  qers_in_if #(.COEF_WIDTH(16)) in_ch();
  qers_out_if out_ch();

  quadratic_exact_root_solver_core #(.COEF_WIDTH(16)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Arithmetic helpers for the root predictor
  // ---------------------------------------------------------------------------
  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic longint unsigned abs_of(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned s;
    s = longint'($sqrt(real'(n)));
    while (s * s > n) s--;
    while ((s + 1) * (s + 1) <= n) s++;
    return s;
  endfunction

  // Divide a fraction by its common factor; a zero part leaves it untouched.
  function automatic void cancel_pair(inout longint p, inout longint q);
    longint unsigned g;
    if (p == 0 || q == 0) return;
    g = gcd_of(abs_of(p), abs_of(q));
    if (g > 1) begin
      p = p / longint'(g);
      q = q / longint'(g);
    end
  endfunction

  function automatic void cancel_triple(inout longint p, inout longint q, inout longint r);
    longint unsigned g;
    if (p == 0 || q == 0 || r == 0) return;
    g = gcd_of(gcd_of(abs_of(p), abs_of(q)), abs_of(r));
    if (g > 1) begin
      p = p / longint'(g);
      q = q / longint'(g);
      r = r / longint'(g);
    end
  endfunction

  // Predict the result item for one equation a*x*x + b*x + c = 0.
  function automatic roots_t solve_roots(longint a, longint b, longint c);
    roots_t r;
    longint delta, den, n1, d1, n2, d2, kb, kk, kd;
    longint unsigned ud, s, m, k, p;
    r = '{default: '0};
    if (a == 0) begin
      r.kind = qers_pkg::KIND_A_ZERO;
      return r;
    end
    delta = b * b - 4 * a * c;
    den   = 2 * a;
    if (delta < 0) begin
      r.kind = qers_pkg::KIND_NONE;
    end else if (delta == 0) begin
      n1 = -b;
      d1 = den;
      cancel_pair(n1, d1);
      r.kind      = qers_pkg::KIND_DOUBLE;
      r.first_num = n1[qers_pkg::NUM_W-1:0];
      r.first_den = d1[qers_pkg::DEN_W-1:0];
    end else begin
      ud = longint'(delta);
      s  = int_sqrt(ud);
      if (s * s == ud) begin
        n1 = -b + longint'(s);
        n2 = -b - longint'(s);
        d1 = den;
        d2 = den;
        cancel_pair(n1, d1);
        cancel_pair(n2, d2);
        r.kind       = qers_pkg::KIND_RATIONAL;
        r.first_num  = n1[qers_pkg::NUM_W-1:0];
        r.first_den  = d1[qers_pkg::DEN_W-1:0];
        r.second_num = n2[qers_pkg::NUM_W-1:0];
        r.second_den = d2[qers_pkg::DEN_W-1:0];
      end else begin
        // split delta = k*k*rest by trial division, pairs of each prime go to k
        m = ud;
        k = 1;
        for (p = 2; p * p <= m; p++) begin
          while (m % p == 0) begin
            m = m / p;
            if (m % p == 0) begin
              m = m / p;
              k = k * p;
            end else begin
              break;
            end
          end
        end
        m  = ud / (k * k);
        kb = b;
        kk = longint'(k);
        kd = den;
        if (k > 1) begin
          if (kb == 0) cancel_pair(kk, kd);
          else cancel_triple(kb, kk, kd);
        end
        kb = -kb;
        r.kind          = qers_pkg::KIND_IRRATION;
        r.rational_part = kb[qers_pkg::RAT_W-1:0];
        r.radical_coeff = kk[qers_pkg::RADC_W-1:0];
        r.radical_rest  = m[qers_pkg::REST_W-1:0];
        r.irr_den       = kd[qers_pkg::DEN_W-1:0];
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one item per call, random gap before it, prediction queued on accept
  // ---------------------------------------------------------------------------
  task automatic send_equation(int a, int b, int c);
    int gap;
    gap = $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.coef_a <= a[15:0];
    in_ch.coef_b <= b[15:0];
    in_ch.coef_c <= c[15:0];
    do @(posedge clk); while (!in_ch.ready);
    pending_roots.push_back(solve_roots(a, b, c));
    @(negedge clk);
  endtask

  function automatic int rand_coef(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls on ready, every accepted item checked in order
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 12);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    roots_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_roots.size() == 0) begin
        $error("result item with no equation pending");
        fails++;
      end else begin
        w = pending_roots.pop_front();
        check_field("kind", w.kind, out_ch.kind);
        check_field("first_num", w.first_num, out_ch.first_num);
        check_field("first_den", w.first_den, out_ch.first_den);
        check_field("second_num", w.second_num, out_ch.second_num);
        check_field("second_den", w.second_den, out_ch.second_den);
        check_field("rational_part", w.rational_part, out_ch.rational_part);
        check_field("radical_coeff", w.radical_coeff, out_ch.radical_coeff);
        check_field("radical_rest", w.radical_rest, out_ch.radical_rest);
        check_field("irr_den", w.irr_den, out_ch.irr_den);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes and every special case of the classification.
  task automatic test_directed();
    send_equation(0, 5, 7);              // a zero
    send_equation(0, -32768, 32767);     // a zero, extreme b/c
    send_equation(32767, 0, 32767);      // no real roots
    send_equation(-32768, 1, -32768);    // no real roots, a at minimum
    send_equation(1, 2, 1);              // double root
    send_equation(-2, 4, -2);            // double root, negative 2a kept
    send_equation(3, 0, 0);              // double root, zero numerator
    send_equation(1, -32768, 0);         // rational pair, delta = 2^30
    send_equation(1, 2, 0);              // rational pair, first numerator zero
    send_equation(1, -2, 0);             // rational pair, second numerator zero
    send_equation(6, -5, 1);             // rational pair, both reduced
    send_equation(1, 1, -1);             // irrational, k = 1
    send_equation(1, 0, -8);             // irrational, b zero: k and 2a only
    send_equation(3, 6, -3);             // irrational, three-way reduction
    send_equation(-1, 4, 4);             // irrational, negative denominator
    send_equation(-32768, -32768, 32767);// extreme irrational
    send_equation(32767, 32767, -32768); // extreme, mixed signs
    send_equation(-1, -1, -1);           // all ones
  endtask

  // Hold the sender until the block has drained completely.
  task automatic test_drain_pause();
    send_equation(2, 7, 3);
    send_equation(5, 1, -9);
    in_ch.valid <= 1'b0;
    while (pending_roots.size() != 0) @(negedge clk);
    send_equation(4, -12, 9);
  endtask

  // Products of two linear factors: rational pairs and double roots.
  task automatic test_factored(int n);
    int m1, r1, m2, r2;
    repeat (n) begin
      m1 = rand_coef(12);
      m2 = rand_coef(12);
      r1 = rand_coef(30);
      r2 = rand_coef(30);
      if (m1 == 0) m1 = 1;
      if (m2 == 0) m2 = -1;
      send_equation(m1 * m2, -(m1 * r2 + m2 * r1), r1 * r2);
    end
  endtask

  // Small coefficients keep the trial division short.
  task automatic test_small_random(int n);
    int lim;
    repeat (n) begin
      case ($urandom_range(0, 2))
        0: lim = 4;
        1: lim = 40;
        default: lim = 250;
      endcase
      send_equation(rand_coef(lim), rand_coef(lim), rand_coef(lim));
    end
  endtask

  // A few full-range items so every input bit toggles.
  task automatic test_full_range(int n);
    repeat (n)
      send_equation($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                    $urandom_range(0, 65535) - 32768);
  endtask

  initial begin
    fails        = 0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.coef_a = '0;
    in_ch.coef_b = '0;
    in_ch.coef_c = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_drain_pause();
    test_factored(30);
    test_small_random(45);
    test_full_range(4);
    in_ch.valid <= 1'b0;

    while (pending_roots.size() != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("[quadratic_exact_root_solver_core] OK");
    end else begin
      $display("[quadratic_exact_root_solver_core] ERROR");
    end
    $finish;
  end

  // Timeout; the worst case is a large prime discriminant, whose trial division runs longest.
  initial begin
    repeat (400) #10_000_000;
    $display("[quadratic_exact_root_solver_core] ERROR");
    $finish;
  end

endmodule

// File: files.f
sv/qers_pkg.sv
sv/qers_if.sv
sv/qers_div.sv
sv/quadratic_exact_root_solver_core.sv
tb/tb_top.sv
